### sv/hre_pkg.sv
// hre_pkg: types, codes and helper functions shared by the hex record emitter
// used by hre_req_if, hre_ctrl, hre_datapath and hex_record_emitter_core
package hre_pkg;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 16;
   localparam int MAX_RESULTS = 54;
   localparam int RUN_W       = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 3;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_WORD  = 2'd1,
      ACT_FLUSH = 2'd2,
      ACT_LOAD  = 2'd3
   } action_type;

   localparam logic [1:0] FMT_HEX  = 2'd0;
   localparam logic [1:0] FMT_DUMP = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_EMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRLF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIG    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BPA    = 3'd5;

   localparam logic [7:0] CH_COLON   = 8'h3a;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PUSH,
      ST_REC_START,
      ST_COLON,
      ST_COUNT,
      ST_ADDR,
      ST_TYPE,
      ST_SPACE,
      ST_DATA,
      ST_SUM,
      ST_CR,
      ST_LF,
      ST_REC_END
   } state_type;

   typedef enum logic [2:0] {
      SEL_NIBBLE,
      SEL_COLON,
      SEL_SPACE,
      SEL_CR,
      SEL_LF
   } char_sel_type;

   typedef enum logic [2:0] {
      SRC_COUNT,
      SRC_ADDR,
      SRC_ZERO,
      SRC_DATA,
      SRC_SUM
   } field_src_type;

   typedef struct packed {
      logic          load_item;
      logic          push;
      logic          second;
      logic          load_addr;
      logic          load_chk;
      logic          rec_close;
      logic          idx_clear;
      logic          idx_step;
      logic          emit;
      logic          last;
      char_sel_type  sel;
      field_src_type src;
      logic [1:0]    digit;
   } cmd_type;

   typedef struct packed {
      logic       emit_enable;
      logic [1:0] format;
      logic       crlf;
      action_type action;
      logic       row_empty;
      logic       push_fills;
      logic       idx_last;
      logic       slot_free;
   } stat_type;

   function automatic logic [2:0] unit_size(input logic [2:0] bpa);
      logic [2:0] size;
      if (bpa == 3'd0) begin
         size = 3'd1;
      end else if (bpa > 3'd4) begin
         size = 3'd4;
      end else begin
         size = bpa;
      end
      return size;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'h0, nib};
      end else begin
         ch = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'h0, nib} - 8'd10;
      end
      return ch;
   endfunction

endpackage

### sv/hre_req_if.sv
// hre_req_if: input transaction channel of the hex record emitter
// depends on hre_pkg
interface hre_req_if;
   logic                            valid;
   logic                            ready;
   hre_pkg::action_type             action;
   logic [hre_pkg::DATA_W-1:0]      data;
   logic [hre_pkg::ADDR_W-1:0]      load_address;

   modport source (output valid, action, data, load_address, input ready);
   modport sink (input valid, action, data, load_address, output ready);
endinterface

### sv/hre_rsp_if.sv
// hre_rsp_if: character output channel of the hex record emitter
// depends on nothing
interface hre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       last;

   modport source (output valid, ascii_char, last, input ready);
   modport sink (input valid, ascii_char, last, output ready);
endinterface

### sv/hre_ctrl.sv
// hre_ctrl: state machine that sequences byte pushes and record characters
// depends on hre_pkg; drives hre_datapath through cmd_type
module hre_ctrl #(
   parameter int ROW_BYTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hre_pkg::stat_type stat,
   output hre_pkg::cmd_type  cmd
);
   import hre_pkg::*;

   localparam logic ONE_BYTE_ROW = (ROW_BYTES == 1);

   state_type        state_ff, state_in;
   logic             second_ff, second_in;
   logic             pend_ff, pend_in;
   logic             final_ff, final_in;
   logic [1:0]       digit_ff, digit_in;
   logic [RUN_W-1:0] run_cnt_ff, run_cnt_in;

   logic more;
   logic step;
   logic eol_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         second_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         final_ff   <= 1'b0;
         digit_ff   <= 2'd0;
         run_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         second_ff  <= second_in;
         pend_ff    <= pend_in;
         final_ff   <= final_in;
         digit_ff   <= digit_in;
         run_cnt_ff <= run_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      second_in  = second_ff;
      pend_in    = pend_ff;
      final_in   = final_ff;
      digit_in   = digit_ff;
      run_cnt_in = run_cnt_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.sel    = SEL_NIBBLE;
      cmd.src    = SRC_ZERO;
      cmd.digit  = digit_ff;
      cmd.second = second_ff;
      more       = (stat.action == ACT_WORD) && !second_ff;
      eol_next   = 1'b0;
      step       = (state_ff inside {ST_COLON, ST_COUNT, ST_ADDR, ST_TYPE, ST_SPACE,
                                     ST_DATA, ST_SUM, ST_CR, ST_LF}) && stat.slot_free;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               run_cnt_in    = '0;
               second_in     = 1'b0;
               pend_in       = 1'b0;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.action)
               ACT_BYTE, ACT_WORD: begin
                  state_in = ST_PUSH;
               end
               ACT_FLUSH: begin
                  final_in = 1'b1;
                  state_in = stat.emit_enable ? ST_REC_START : ST_IDLE;
               end
               default: begin
                  cmd.load_addr = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end
         ST_PUSH: begin
            cmd.push  = 1'b1;
            second_in = 1'b1;
            pend_in   = more;
            if (stat.push_fills) begin
               final_in = !(more && ONE_BYTE_ROW);
               state_in = ST_REC_START;
            end else if (more) begin
               state_in = ST_PUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REC_START: begin
            cmd.load_chk  = 1'b1;
            cmd.idx_clear = 1'b1;
            if (!stat.row_empty && (stat.format == FMT_HEX || stat.format == FMT_DUMP)) begin
               state_in = ST_COLON;
            end else begin
               state_in = ST_REC_END;
            end
         end
         ST_COLON: begin
            cmd.sel = SEL_COLON;
            if (step) begin
               if (stat.format == FMT_HEX) begin
                  digit_in = 2'd1;
                  state_in = ST_COUNT;
               end else begin
                  digit_in = 2'd3;
                  state_in = ST_ADDR;
               end
            end
         end
         ST_COUNT: begin
            cmd.src = SRC_COUNT;
            if (step) begin
               if (digit_ff == 2'd0) begin
                  digit_in = 2'd3;
                  state_in = ST_ADDR;
               end else begin
                  digit_in = digit_ff - 2'd1;
               end
            end
         end
         ST_ADDR: begin
            cmd.src = SRC_ADDR;
            if (step) begin
               if (digit_ff == 2'd0) begin
                  digit_in = 2'd1;
                  state_in = (stat.format == FMT_HEX) ? ST_TYPE : ST_SPACE;
               end else begin
                  digit_in = digit_ff - 2'd1;
               end
            end
         end
         ST_TYPE: begin
            cmd.src = SRC_ZERO;
            if (step) begin
               if (digit_ff == 2'd0) begin
                  digit_in = 2'd1;
                  state_in = ST_DATA;
               end else begin
                  digit_in = digit_ff - 2'd1;
               end
            end
         end
         ST_SPACE: begin
            cmd.sel = SEL_SPACE;
            if (step) begin
               digit_in = 2'd1;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            cmd.src = SRC_DATA;
            if (step) begin
               if (digit_ff == 2'd0) begin
                  cmd.idx_step = 1'b1;
                  digit_in     = 2'd1;
                  if (stat.idx_last) begin
                     if (stat.format == FMT_HEX) begin
                        state_in = ST_SUM;
                     end else begin
                        eol_next = 1'b1;
                     end
                  end else begin
                     state_in = (stat.format == FMT_HEX) ? ST_DATA : ST_SPACE;
                  end
               end else begin
                  digit_in = digit_ff - 2'd1;
               end
            end
         end
         ST_SUM: begin
            cmd.src = SRC_SUM;
            if (step) begin
               if (digit_ff == 2'd0) begin
                  eol_next = 1'b1;
               end else begin
                  digit_in = digit_ff - 2'd1;
               end
            end
         end
         ST_CR: begin
            cmd.sel = SEL_CR;
            if (step) begin
               state_in = ST_LF;
            end
         end
         ST_LF: begin
            cmd.sel  = SEL_LF;
            cmd.last = final_ff;
            if (step) begin
               state_in = ST_REC_END;
            end
         end
         ST_REC_END: begin
            cmd.rec_close = 1'b1;
            state_in      = pend_ff ? ST_PUSH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (eol_next) begin
         state_in = stat.crlf ? ST_CR : ST_LF;
      end

      // characters past the cap are dropped, but the final one always goes out
      if (step) begin
         cmd.emit = (run_cnt_ff < RUN_W'(MAX_RESULTS - 1)) || cmd.last;
         if (run_cnt_ff != '1) begin
            run_cnt_in = run_cnt_ff + 1'b1;
         end
      end
   end

endmodule

### sv/hre_datapath.sv
// hre_datapath: control registers, row buffer, address tracking, checksum,
// character formatting and the output register; depends on hre_pkg
module hre_datapath #(
   parameter int ROW_BYTES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [hre_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hre_pkg::CSR_DATA_W-1:0]    csr_data,
   input  hre_pkg::action_type               req_action,
   input  logic [hre_pkg::DATA_W-1:0]        req_data,
   input  logic [hre_pkg::ADDR_W-1:0]        req_load_address,
   input  hre_pkg::cmd_type                  cmd,
   output hre_pkg::stat_type                 stat,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [7:0]                        rsp_char,
   output logic                              rsp_last
);
   import hre_pkg::*;

   localparam int RC_W  = $clog2(ROW_BYTES + 1);
   localparam int IDX_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   // control registers
   logic       emit_ff, upper_ff, crlf_ff, big_ff;
   logic [1:0] format_ff;
   logic [2:0] bpa_ff;

   // item holding registers
   action_type        action_ff;
   logic [DATA_W-1:0] data_ff;
   logic [ADDR_W-1:0] load_addr_ff;

   // row and address state
   logic [7:0]        row_buf_ff [ROW_BYTES];
   logic [RC_W-1:0]   rc_ff, rc_in;
   logic [ADDR_W-1:0] row_start_ff, row_start_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [2:0]        bleft_ff, bleft_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        chk_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff;
   logic              out_last_ff;

   logic [7:0]        push_byte;
   logic              push_wr;
   logic [15:0]       field;
   logic [3:0]        nibble;
   logic [7:0]        ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff   <= 1'b1;
         format_ff <= FMT_HEX;
         upper_ff  <= 1'b1;
         crlf_ff   <= 1'b0;
         big_ff    <= 1'b0;
         bpa_ff    <= 3'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EMIT:   emit_ff   <= csr_data[0];
            CSR_FORMAT: format_ff <= csr_data[1:0];
            CSR_UPPER:  upper_ff  <= csr_data[0];
            CSR_CRLF:   crlf_ff   <= csr_data[0];
            CSR_BIG:    big_ff    <= csr_data[0];
            CSR_BPA:    bpa_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff    <= req_action;
         data_ff      <= req_data;
         load_addr_ff <= req_load_address;
      end
   end

   assign push_byte = ((action_ff == ACT_WORD) && (cmd.second ^ big_ff)) ? data_ff[15:8]
                                                                         : data_ff[7:0];
   assign push_wr   = cmd.push && emit_ff && (rc_ff < RC_W'(ROW_BYTES));

   always_ff @(posedge clock) begin
      if (push_wr) begin
         row_buf_ff[rc_ff[IDX_W-1:0]] <= push_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_chk) begin
         chk_ff <= 8'h00 - (8'(rc_ff) + row_start_ff[7:0] + row_start_ff[15:8] + sum_ff);
      end
   end

   always_comb begin
      rc_in        = rc_ff;
      row_start_in = row_start_ff;
      cur_in       = cur_ff;
      bleft_in     = bleft_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      if (push_wr) begin
         rc_in  = rc_ff + 1'b1;
         sum_in = sum_ff + push_byte;
      end
      if (cmd.push) begin
         if (bleft_ff <= 3'd1) begin
            cur_in   = cur_ff + 1'b1;
            bleft_in = unit_size(bpa_ff);
         end else begin
            bleft_in = bleft_ff - 3'd1;
         end
      end
      if (cmd.load_addr) begin
         cur_in = load_addr_ff;
      end
      if (cmd.rec_close) begin
         rc_in        = '0;
         sum_in       = 8'h00;
         row_start_in = cur_ff;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff        <= '0;
         row_start_ff <= '0;
         cur_ff       <= '0;
         bleft_ff     <= 3'd1;
         sum_ff       <= 8'h00;
         idx_ff       <= '0;
      end else begin
         rc_ff        <= rc_in;
         row_start_ff <= row_start_in;
         cur_ff       <= cur_in;
         bleft_ff     <= bleft_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
      end
   end

   always_comb begin
      case (cmd.src)
         SRC_COUNT: field = 16'(rc_ff);
         SRC_ADDR:  field = row_start_ff;
         SRC_DATA:  field = {8'h00, row_buf_ff[idx_ff]};
         SRC_SUM:   field = {8'h00, chk_ff};
         default:   field = 16'h0000;
      endcase
      nibble = field[{cmd.digit, 2'b00} +: 4];
      case (cmd.sel)
         SEL_COLON: ch = CH_COLON;
         SEL_SPACE: ch = CH_SPACE;
         SEL_CR:    ch = CH_CR;
         SEL_LF:    ch = CH_LF;
         default:   ch = hex_char(nibble, upper_ff);
      endcase
   end

   // output register: holds one character until it is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_char_ff <= ch;
         out_last_ff <= cmd.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_char  = out_char_ff;
   assign rsp_last  = out_last_ff;

   assign stat.emit_enable = emit_ff;
   assign stat.format      = format_ff;
   assign stat.crlf        = crlf_ff;
   assign stat.action      = action_ff;
   assign stat.row_empty   = (rc_ff == '0);
   assign stat.push_fills  = emit_ff && (rc_ff == RC_W'(ROW_BYTES - 1));
   assign stat.idx_last    = ((RC_W'(idx_ff) + 1'b1) == rc_ff);
   assign stat.slot_free   = !out_valid_ff || rsp_ready;

endmodule

### sv/hex_record_emitter_core.sv
// hex_record_emitter_core: byte/word input, one ASCII character per output transaction
// closing a row, even an empty or silent one, passes through ST_REC_START and ST_REC_END,
// and each character waits for a free output slot
// throughput: one transaction at a time, set by the character sequencer (one char per cycle while the output is taken)
// reset: synchronous; clears control state and restores register defaults, row buffer kept
// depends on hre_pkg, hre_req_if, hre_rsp_if, hre_ctrl, hre_datapath
module hex_record_emitter_core #(
   parameter int ROW_BYTES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   hre_req_if.sink                        req_ch,
   hre_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [hre_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hre_pkg::CSR_DATA_W-1:0] csr_data
);
   import hre_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   hre_ctrl #(
      .ROW_BYTES(ROW_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hre_datapath #(
      .ROW_BYTES(ROW_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_action       (req_ch.action),
      .req_data         (req_ch.data),
      .req_load_address (req_ch.load_address),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_char         (rsp_ch.ascii_char),
      .rsp_last         (rsp_ch.last)
   );

   assign req_ch.ready = req_ready;

   // never overwrite a character still waiting at the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.slot_free)
      else $error("character issued while output register is occupied");

   // no characters are produced while waiting for a transaction
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.emit && !cmd.push)
      else $error("datapath activity while idle");

   // an accepted transaction holds off the next one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted back to back");

endmodule

### tb/sv/hex_record_emitter_core_tb.sv
`timescale 1ns / 100ps
// hex_record_emitter_core_tb: sends byte, word, flush and load transactions, predicts every
// output character of the text records and checks it; needs hre_pkg, hre_req_if, hre_rsp_if
module hex_record_emitter_core_tb;
   import hre_pkg::*;

   localparam int ROW_BYTES       = 16;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int RUN_LIMIT_NS    = 5_000_000;

   localparam logic [1:0] FMT_SILENT     = 2'd2;
   localparam logic [1:0] FMT_SILENT_ALT = 2'd3;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   typedef struct packed {
      logic       emit;
      logic [1:0] fmt;
      logic       upper;
      logic       crlf;
      logic       big;
      logic [2:0] bpa;
   } emitter_settings_type;

   class hex_text_tracker_type;
      logic          emit_on;
      logic [1:0]    fmt;
      logic          upper;
      logic          crlf;
      logic          big;
      logic [2:0]    bpa;
      logic [7:0]    row_bytes [ROW_BYTES];
      int unsigned   row_count;
      logic [15:0]   row_addr;
      logic [15:0]   cur_addr;
      int unsigned   unit_left;
      logic [7:0]    line_text [$];
      char_beat_type expected_chars [$];
      int            errors;
      int            checked;
      int            records;

      function new();
         emit_on   = 1'b1;
         fmt       = FMT_HEX;
         upper     = 1'b1;
         crlf      = 1'b0;
         big       = 1'b0;
         bpa       = 3'd1;
         row_count = 0;
         row_addr  = '0;
         cur_addr  = '0;
         unit_left = 1;
         errors    = 0;
         checked   = 0;
         records   = 0;
      endfunction

      function void apply(emitter_settings_type s);
         emit_on = s.emit;
         fmt     = s.fmt;
         upper   = s.upper;
         crlf    = s.crlf;
         big     = s.big;
         bpa     = s.bpa;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function void put_hex(int unsigned v, int digits);
         logic [3:0] nib;
         int i;
         for (i = digits - 1; i >= 0; i--) begin
            nib = 4'(v >> (4 * i));
            if (nib < 4'd10) begin
               line_text.push_back(CH_ZERO + 8'(nib));
            end else begin
               line_text.push_back((upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10);
            end
         end
      endfunction

      function void put_eol();
         if (crlf) begin
            line_text.push_back(CH_CR);
         end
         line_text.push_back(CH_LF);
      endfunction

      function void close_row();
         logic [7:0] sum;
         int k;
         if (!emit_on) begin
            return;
         end
         if (row_count > 0) begin
            if (fmt == FMT_DUMP) begin
               line_text.push_back(CH_COLON);
               put_hex(row_addr, 4);
               for (k = 0; k < row_count; k++) begin
                  line_text.push_back(CH_SPACE);
                  put_hex(row_bytes[k], 2);
               end
               put_eol();
            end else if (fmt == FMT_HEX) begin
               line_text.push_back(CH_COLON);
               put_hex(row_count, 2);
               put_hex(row_addr, 4);
               put_hex(0, 2);
               sum = 8'(row_count) + row_addr[7:0] + row_addr[15:8];
               for (k = 0; k < row_count; k++) begin
                  put_hex(row_bytes[k], 2);
                  sum = sum + row_bytes[k];
               end
               sum = 8'd0 - sum;
               put_hex(sum, 2);
               put_eol();
            end
         end
         row_count = 0;
         row_addr  = cur_addr;
      endfunction

      function void push_byte(logic [7:0] b);
         if (emit_on && row_count < ROW_BYTES) begin
            row_bytes[row_count] = b;
            row_count++;
         end
         if (unit_left <= 1) begin
            cur_addr++;
            unit_left = (bpa == 3'd0) ? 1 : (bpa > 3'd4) ? 4 : bpa;
         end else begin
            unit_left--;
         end
         if (emit_on && row_count >= ROW_BYTES) begin
            close_row();
         end
      endfunction

      function void note_item(action_type act, logic [15:0] word, logic [15:0] new_addr);
         int n;
         int k;
         line_text.delete();
         case (act)
            ACT_BYTE: begin
               push_byte(word[7:0]);
            end
            ACT_WORD: begin
               if (big) begin
                  push_byte(word[15:8]);
                  push_byte(word[7:0]);
               end else begin
                  push_byte(word[7:0]);
                  push_byte(word[15:8]);
               end
            end
            ACT_FLUSH: begin
               close_row();
            end
            default: begin
               cur_addr = new_addr;
            end
         endcase
         n = line_text.size();
         // an overlong run keeps its head and its final character
         if (n > MAX_RESULTS) begin
            line_text[MAX_RESULTS - 1] = line_text[n - 1];
            n = MAX_RESULTS;
         end
         if (n > 0) begin
            records++;
         end
         for (k = 0; k < n; k++) begin
            expected_chars.push_back('{ch: line_text[k], last: (k == n - 1)});
         end
      endfunction

      function void check_char(logic [7:0] ch, logic last);
         char_beat_type exp_beat;
         checked++;
         if (expected_chars.size() == 0) begin
            $error("ascii_char: expected nothing, got %h", ch);
            errors++;
            return;
         end
         exp_beat = expected_chars.pop_front();
         if (ch !== exp_beat.ch) begin
            $error("ascii_char: expected %h, got %h", exp_beat.ch, ch);
            errors++;
         end
         if (last !== exp_beat.last) begin
            $error("last: expected %b, got %b", exp_beat.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   hre_req_if req_bus ();
   hre_rsp_if rsp_bus ();

   hex_text_tracker_type tracker = new();

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_trigger = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;
   int items_sent = 0;
   int settings_used = 0;

   hex_record_emitter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_trigger != hold_seen) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_trigger;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         tracker.check_char(rsp_bus.ascii_char, rsp_bus.last);
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   task automatic set_pacing(int idle_pct, int stall_pct);
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
   endtask

   task automatic send_item(action_type act, logic [15:0] word, logic [15:0] new_addr);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.data         <= word;
      req_bus.load_address <= new_addr;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_item(act, word, new_addr);
      items_sent++;
   endtask

   task automatic send_random();
      int pick;
      action_type act;
      logic [15:0] word;
      logic [15:0] new_addr;
      pick = $urandom_range(99);
      if (pick < 42) begin
         act = ACT_BYTE;
      end else if (pick < 77) begin
         act = ACT_WORD;
      end else if (pick < 90) begin
         act = ACT_FLUSH;
      end else begin
         act = ACT_LOAD;
      end
      word = 16'($urandom_range(65535));
      if ($urandom_range(4) == 0) begin
         new_addr = 16'hfff0 + 16'($urandom_range(15));
      end else begin
         new_addr = 16'($urandom_range(65535));
      end
      send_item(act, word, new_addr);
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(emitter_settings_type s);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_index <= CSR_EMIT;
      csr_data  <= 3'(s.emit);
      @(posedge clock);
      csr_index <= CSR_FORMAT;
      csr_data  <= 3'(s.fmt);
      @(posedge clock);
      csr_index <= CSR_UPPER;
      csr_data  <= 3'(s.upper);
      @(posedge clock);
      csr_index <= CSR_CRLF;
      csr_data  <= 3'(s.crlf);
      @(posedge clock);
      csr_index <= CSR_BIG;
      csr_data  <= 3'(s.big);
      @(posedge clock);
      csr_index <= CSR_BPA;
      csr_data  <= s.bpa;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.apply(s);
      settings_used++;
   endtask

   function automatic emitter_settings_type phase_settings(int phase);
      emitter_settings_type s;
      case (phase)
         0: s = '{emit: 1'b1, fmt: FMT_HEX, upper: 1'b1, crlf: 1'b0, big: 1'b0, bpa: 3'd1};
         1: s = '{emit: 1'b1, fmt: FMT_DUMP, upper: 1'b0, crlf: 1'b1, big: 1'b1, bpa: 3'd4};
         2: s = '{emit: 1'b1, fmt: FMT_HEX, upper: 1'b0, crlf: 1'b1, big: 1'b1, bpa: 3'd2};
         3: s = '{emit: 1'b1, fmt: FMT_DUMP, upper: 1'b1, crlf: 1'b0, big: 1'b0, bpa: 3'd3};
         default: begin
            s.emit  = 1'b1;
            s.fmt   = ($urandom_range(9) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(1));
            s.upper = 1'($urandom_range(1));
            s.crlf  = 1'($urandom_range(1));
            s.big   = 1'($urandom_range(1));
            s.bpa   = 3'($urandom_range(7));
         end
      endcase
      return s;
   endfunction

   initial begin
      int phase;
      int k;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_BYTE;
      req_bus.data         <= '0;
      req_bus.load_address <= '0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_EMIT;
      csr_data             <= '0;
      set_pacing(0, 0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: intel hex, upper case, lf, little endian, one byte per address
      send_item(ACT_BYTE, 16'hab00, 16'h1234);
      send_item(ACT_BYTE, 16'h00ff, 16'h0000);
      send_item(ACT_WORD, 16'hffff, 16'hffff);
      send_item(ACT_WORD, 16'h1234, 16'h5555);
      send_item(ACT_LOAD, 16'h0000, 16'hfffe);
      send_item(ACT_FLUSH, 16'h0000, 16'h0000);
      // empty row: only the origin moves
      send_item(ACT_FLUSH, 16'hffff, 16'hffff);
      send_item(ACT_WORD, 16'ha5c3, 16'h0000);
      send_item(ACT_FLUSH, 16'h0000, 16'haaaa);

      // full dump row with cr lf runs past the cap
      configure('{emit: 1'b1, fmt: FMT_DUMP, upper: 1'b0, crlf: 1'b1, big: 1'b1, bpa: 3'd4});
      for (k = 0; k < 8; k++) begin
         send_item(ACT_WORD, (k == 0) ? 16'hfedc : 16'($urandom_range(65535)), 16'h0000);
      end

      // output off: address moves, nothing buffered, flush ignored
      configure('{emit: 1'b0, fmt: FMT_HEX, upper: 1'b1, crlf: 1'b0, big: 1'b0, bpa: 3'd0});
      send_item(ACT_BYTE, 16'h005a, 16'h0000);
      send_item(ACT_FLUSH, 16'h0000, 16'h0000);

      // silent formats still clear the row
      configure('{emit: 1'b1, fmt: FMT_SILENT, upper: 1'b1, crlf: 1'b0, big: 1'b0, bpa: 3'd7});
      send_item(ACT_WORD, 16'h8001, 16'h0000);
      send_item(ACT_FLUSH, 16'h0000, 16'h0000);
      configure('{emit: 1'b1, fmt: FMT_SILENT_ALT, upper: 1'b0, crlf: 1'b1, big: 1'b1,
                  bpa: 3'd2});
      send_item(ACT_BYTE, 16'h0077, 16'h0000);
      send_item(ACT_FLUSH, 16'h0000, 16'h0000);

      for (phase = 0; phase < 6; phase++) begin
         configure(phase_settings(phase));
         if (phase == 5) begin
            set_pacing(0, 0);
            hold_trigger <= ~hold_trigger;
         end else begin
            case (phase % 4)
               0: set_pacing(0, 0);
               1: set_pacing(45, 0);
               2: set_pacing(0, 45);
               default: set_pacing(13, 13);
            endcase
         end
         repeat (ITEMS_PER_PHASE) send_random();
      end

      wait_quiet();
      $display("sent %0d transactions under %0d register settings", items_sent, settings_used);
      $display("compared %0d characters in %0d records", tracker.checked, tracker.records);
      if (tracker.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
